FILE: src/per_source_connection_limiter_defines.svh
// Assertion macros shared by the per-source connection limiter RTL.
`ifndef PER_SOURCE_CONNECTION_LIMITER_DEFINES_SVH
`define PER_SOURCE_CONNECTION_LIMITER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PSCL_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pscl assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define PSCL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pscl assertion failed");

`endif

FILE: src/pscl_pkg.sv
// Shared types and constants of the per-source connection limiter.
`timescale 1ns / 1ps

package pscl_pkg;

    localparam int ADDR_W    = 32;
    localparam int LIMIT_W   = 16;
    localparam int OUT_CNT_W = 16;
    localparam int STATUS_W  = 3;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [STATUS_W-1:0] {
        STS_GRANTED     = 3'd0,
        STS_REF_TOTAL   = 3'd1,
        STS_REF_SOURCE  = 3'd2,
        STS_REF_FULL    = 3'd3,
        STS_RELEASED    = 3'd4,
        STS_REL_UNKNOWN = 3'd5
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PER_SOURCE_LIMIT = 2'd0,
        CFG_TOTAL_LIMIT      = 2'd1
    } t_cfg_idx;

    localparam logic OP_GRANT   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    typedef struct packed {
        logic start;
        logic step;
    } t_scan_ctl;

    typedef struct packed {
        logic found;
        logic free_found;
    } t_scan_flags;

endpackage

FILE: src/pscl_req_if.sv
// Request channel: grant or release word for one source address.
`timescale 1ns / 1ps

interface pscl_req_if;
    import pscl_pkg::*;

    logic              valid;
    logic              ready;
    logic              opcode;
    logic [ADDR_W-1:0] source_addr;

    modport source (output valid, output opcode, output source_addr, input ready);
    modport sink (input valid, input opcode, input source_addr, output ready);
endinterface

FILE: src/pscl_rsp_if.sv
// Response channel: status and counts for one request word.
`timescale 1ns / 1ps

interface pscl_rsp_if;
    import pscl_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [STATUS_W-1:0]  status;
    logic [OUT_CNT_W-1:0] source_count;
    logic [OUT_CNT_W-1:0] total_count_out;

    modport source (output valid, output status, output source_count,
                    output total_count_out, input ready);
    modport sink (input valid, input status, input source_count,
                  input total_count_out, output ready);
endinterface

FILE: src/pscl_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module pscl_ram #(
    parameter int WIDTH = 49,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/pscl_match.sv
// Table walk unit: one address compare per cycle, tracks hit and lowest free entry.
`timescale 1ns / 1ps

module pscl_match #(
    parameter int TABLE_ENTRIES = 64,
    parameter int COUNT_BITS    = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  pscl_pkg::t_scan_ctl              i_ctl,
    input  logic [$clog2(TABLE_ENTRIES)-1:0] i_idx,
    input  logic                             i_entry_valid,
    input  logic [pscl_pkg::ADDR_W-1:0]      i_entry_addr,
    input  logic [COUNT_BITS-1:0]            i_entry_cnt,
    input  logic [pscl_pkg::ADDR_W-1:0]      i_key,
    output pscl_pkg::t_scan_flags            o_flags,
    output logic [$clog2(TABLE_ENTRIES)-1:0] o_hit_idx,
    output logic [COUNT_BITS-1:0]            o_hit_cnt,
    output logic [$clog2(TABLE_ENTRIES)-1:0] o_free_idx
);
    import pscl_pkg::*;

    localparam int IW = $clog2(TABLE_ENTRIES);

    t_scan_flags     r_flags, n_flags;
    logic [IW-1:0]   r_hit_idx;
    logic [COUNT_BITS-1:0] r_hit_cnt;
    logic [IW-1:0]   r_free_idx;
    logic            w_hit;

    assign w_hit = i_entry_valid && (i_entry_addr == i_key);

    always_comb begin
        n_flags = r_flags;
        if (i_ctl.start) begin
            n_flags = '0;
        end else if (i_ctl.step) begin
            if (w_hit) begin
                n_flags.found = 1'b1;
            end
            if (!i_entry_valid) begin
                n_flags.free_found = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= '0;
        end else begin
            r_flags <= n_flags;
            // keep the first match and the lowest free slot
            if (i_ctl.step && !i_ctl.start) begin
                if (w_hit && !r_flags.found) begin
                    r_hit_idx <= i_idx;
                    r_hit_cnt <= i_entry_cnt;
                end
                if (!i_entry_valid && !r_flags.free_found) begin
                    r_free_idx <= i_idx;
                end
            end
        end
    end

    assign o_flags    = r_flags;
    assign o_hit_idx  = r_hit_idx;
    assign o_hit_cnt  = r_hit_cnt;
    assign o_free_idx = r_free_idx;

endmodule

FILE: src/per_source_connection_limiter.sv
// Per-source connection limiter: grant/release admission control over an address table.
// Each request word walks the whole source table, one entry per cycle through the
// table RAM's single read port and one address comparator, then decides and writes
// back the entry in ST_DECIDE, which waits until the output register is free (empty
// or being read) and then loads the response into it. A new request is accepted
// only in ST_IDLE, so the block cannot take one before the previous one is decided.
// After reset the table is cleared one entry per cycle, and requests are held off
// until it is cleared; configuration writes are taken at any time. Counts are
// COUNT_BITS wide; the reported counts are their low 16 bits.
`timescale 1ns / 1ps
`include "per_source_connection_limiter_defines.svh"

module per_source_connection_limiter #(
    parameter int TABLE_ENTRIES = 64,
    parameter int COUNT_BITS    = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [pscl_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [pscl_pkg::LIMIT_W-1:0]     i_cfg_data,
    pscl_req_if.sink                         i_req,
    pscl_rsp_if.source                       o_rsp
);
    import pscl_pkg::*;

    localparam int IW = $clog2(TABLE_ENTRIES);
    localparam int SW = $clog2(TABLE_ENTRIES + 1);
    localparam int CW = COUNT_BITS;
    localparam int LW = (CW > LIMIT_W) ? CW : LIMIT_W;
    localparam int WW = 1 + ADDR_W + CW;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE
    } t_state;

    t_state               r_state, n_state;
    logic [IW-1:0]        r_clr_idx, n_clr_idx;
    logic [SW-1:0]        r_scan, n_scan;
    logic                 r_op, n_op;
    logic [ADDR_W-1:0]    r_addr, n_addr;
    logic [LIMIT_W-1:0]   r_psl, n_psl;
    logic [LIMIT_W-1:0]   r_tl, n_tl;
    logic [CW-1:0]        r_total, n_total;
    logic                 r_out_valid, n_out_valid;
    t_status              r_out_status, n_out_status;
    logic [OUT_CNT_W-1:0] r_out_src, n_out_src;
    logic [OUT_CNT_W-1:0] r_out_tot, n_out_tot;

    // table RAM
    logic                 w_we;
    logic [IW-1:0]        w_waddr;
    logic [WW-1:0]        w_wdata;
    logic [IW-1:0]        w_raddr;
    logic [WW-1:0]        w_rdata;

    // walk unit
    t_scan_ctl            w_ctl;
    t_scan_flags          w_flags;
    logic [SW-1:0]        w_prev;
    logic [IW-1:0]        w_hit_idx;
    logic [CW-1:0]        w_hit_cnt;
    logic [IW-1:0]        w_free_idx;

    // decision
    logic [CW-1:0]        w_cur;
    t_status              d_status;
    logic [CW-1:0]        d_cur;
    logic [CW-1:0]        d_total;
    logic                 d_we;
    logic [IW-1:0]        d_widx;
    logic [WW-1:0]        d_wdata;
    logic [LW-1:0]        w_cur_x;
    logic [LW-1:0]        w_tot_x;
    logic                 w_fire;

    pscl_ram #(
        .WIDTH (WW),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_prev  = r_scan - SW'(1);
    assign w_raddr = r_scan[IW-1:0];

    pscl_match #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .COUNT_BITS    (COUNT_BITS)
    ) u_match (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (w_ctl),
        .i_idx         (w_prev[IW-1:0]),
        .i_entry_valid (w_rdata[WW-1]),
        .i_entry_addr  (w_rdata[WW-2 -: ADDR_W]),
        .i_entry_cnt   (w_rdata[CW-1:0]),
        .i_key         (r_addr),
        .o_flags       (w_flags),
        .o_hit_idx     (w_hit_idx),
        .o_hit_cnt     (w_hit_cnt),
        .o_free_idx    (w_free_idx)
    );

    assign w_cur  = w_flags.found ? w_hit_cnt : '0;
    assign w_fire = !r_out_valid || o_rsp.ready;

    always_comb begin
        d_status = STS_GRANTED;
        d_cur    = w_cur;
        d_total  = r_total;
        d_we     = 1'b0;
        d_widx   = w_flags.found ? w_hit_idx : w_free_idx;
        d_wdata  = '0;
        if (r_op == OP_GRANT) begin
            if (((r_tl != '0) && (LW'(r_total) >= LW'(r_tl))) || (r_total == {CW{1'b1}})) begin
                d_status = STS_REF_TOTAL;
            end else if (r_psl != '0) begin
                if ((LW'(w_cur) >= LW'(r_psl)) || (w_cur == {CW{1'b1}})) begin
                    d_status = STS_REF_SOURCE;
                end else if (!w_flags.found && !w_flags.free_found) begin
                    d_status = STS_REF_FULL;
                end else begin
                    d_we    = 1'b1;
                    d_wdata = {1'b1, r_addr, w_cur + CW'(1)};
                    d_cur   = w_cur + CW'(1);
                    d_total = r_total + CW'(1);
                end
            end else begin
                d_total = r_total + CW'(1);
            end
        end else begin
            if (w_flags.found) begin
                d_status = STS_RELEASED;
                d_we     = 1'b1;
                if (w_hit_cnt > CW'(1)) begin
                    d_wdata = {1'b1, r_addr, w_hit_cnt - CW'(1)};
                    d_cur   = w_hit_cnt - CW'(1);
                end else begin
                    // free the entry
                    d_wdata = {1'b0, r_addr, {CW{1'b0}}};
                    d_cur   = '0;
                end
            end else begin
                d_status = STS_REL_UNKNOWN;
                d_cur    = '0;
            end
            if (r_total != '0) begin
                d_total = r_total - CW'(1);
            end
        end
    end

    assign w_cur_x = LW'(d_cur);
    assign w_tot_x = LW'(d_total);

    always_comb begin
        n_state      = r_state;
        n_clr_idx    = r_clr_idx;
        n_scan       = r_scan;
        n_op         = r_op;
        n_addr       = r_addr;
        n_psl        = r_psl;
        n_tl         = r_tl;
        n_total      = r_total;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        n_out_status = r_out_status;
        n_out_src    = r_out_src;
        n_out_tot    = r_out_tot;
        w_we         = 1'b0;
        w_waddr      = r_clr_idx;
        w_wdata      = '0;
        w_ctl        = '0;

        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_PER_SOURCE_LIMIT: n_psl = i_cfg_data;
                CFG_TOTAL_LIMIT:      n_tl  = i_cfg_data;
                default: ;
            endcase
        end

        case (r_state)
            ST_CLEAR: begin
                w_we      = 1'b1;
                n_clr_idx = r_clr_idx + IW'(1);
                if (r_clr_idx == IW'(TABLE_ENTRIES - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_req.valid) begin
                    n_op      = i_req.opcode;
                    n_addr    = i_req.source_addr;
                    n_scan    = '0;
                    w_ctl.start = 1'b1;
                    n_state   = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // read data arrives in the cycle after its address
                w_ctl.step = (r_scan != '0);
                if (r_scan == SW'(TABLE_ENTRIES)) begin
                    n_state = ST_DECIDE;
                end else begin
                    n_scan = r_scan + SW'(1);
                end
            end
            ST_DECIDE: begin
                // hold until the output register is free
                if (w_fire) begin
                    w_we         = d_we;
                    w_waddr      = d_widx;
                    w_wdata      = d_wdata;
                    n_total      = d_total;
                    n_out_valid  = 1'b1;
                    n_out_status = d_status;
                    n_out_src    = w_cur_x[OUT_CNT_W-1:0];
                    n_out_tot    = w_tot_x[OUT_CNT_W-1:0];
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_idx   <= '0;
            r_scan      <= '0;
            r_psl       <= '0;
            r_tl        <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_clr_idx    <= n_clr_idx;
            r_scan       <= n_scan;
            r_op         <= n_op;
            r_addr       <= n_addr;
            r_psl        <= n_psl;
            r_tl         <= n_tl;
            r_total      <= n_total;
            r_out_valid  <= n_out_valid;
            r_out_status <= n_out_status;
            r_out_src    <= n_out_src;
            r_out_tot    <= n_out_tot;
        end
    end

    assign i_req.ready           = (r_state == ST_IDLE);
    assign o_rsp.valid           = r_out_valid;
    assign o_rsp.status          = r_out_status;
    assign o_rsp.source_count    = r_out_src;
    assign o_rsp.total_count_out = r_out_tot;

    `PSCL_ASSERT_NEXT(a_accept_starts_walk, i_clk, i_rst_n, i_req.valid && i_req.ready, r_state == ST_SCAN)
    `PSCL_ASSERT_IMPL(a_result_from_decide, i_clk, i_rst_n, $rose(r_out_valid), $past(r_state == ST_DECIDE))
    `PSCL_ASSERT_NEXT(a_grant_bumps_total, i_clk, i_rst_n, (r_state == ST_DECIDE) && w_fire && (r_op == OP_GRANT) && (d_status == STS_GRANTED), r_total == $past(r_total) + CW'(1))
    `PSCL_ASSERT_NEXT(a_release_drops_total, i_clk, i_rst_n, (r_state == ST_DECIDE) && w_fire && (r_op == OP_RELEASE) && (r_total != '0), r_total == $past(r_total) - CW'(1))

endmodule
